// File: rtl/etq_pkg.sv
package etq_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int OUT_FRAC_BITS = 15;
	localparam int CORDIC_STAGES = 16;
	localparam int WORK_FRAC     = 30;
	localparam int CW            = 34;
	localparam int ZW            = 35;
	localparam logic signed [CW-1:0] INV_GAIN = CW'(652032874);
	localparam int OUT_SH        = WORK_FRAC - OUT_FRAC_BITS;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] angle_x;
		logic signed [ANGLE_BITS-1:0] angle_y;
		logic signed [ANGLE_BITS-1:0] angle_z;
	} req_in_t;

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} req_out_t;

	typedef struct packed {
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] s;
	} cs_t;

	function automatic logic signed [ZW-1:0] atan_t(input int i);
		logic [31:0] v;
		case (i)
			0:  v = 32'h20000000;  1: v = 32'h12E4051D;  2: v = 32'h09FB385B;
			3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
			9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
			12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2F9;
			15: v = 32'h0000517C; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
			18: v = 32'h00000A2F; 19: v = 32'h00000517; 20: v = 32'h0000028B;
			21: v = 32'h00000145; 22: v = 32'h000000A2; 23: v = 32'h00000051;
			24: v = 32'h00000028; 25: v = 32'h00000014; 26: v = 32'h0000000A;
			27: v = 32'h00000005; 28: v = 32'h00000002; 29: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return {2'b00, v, 1'b0};
	endfunction

	function automatic logic signed [CW-1:0] rnd30(input logic signed [CW+CW+1:0] v);
		logic signed [CW+CW+1:0] t;
		t = v + (CW+CW+2)'(64'sd1 <<< (WORK_FRAC-1));
		return CW'(t >>> WORK_FRAC);
	endfunction

	function automatic logic signed [15:0] to_out(input logic signed [CW-1:0] v);
		logic signed [CW:0] t;
		if (OUT_SH == 0)
			t = (CW+1)'(v);
		else
			t = ((CW+1)'(v) + (CW+1)'(64'sd1 <<< (OUT_SH > 0 ? OUT_SH-1 : 0))) >>> OUT_SH;
		if (t > 32767)
			return 16'sh7FFF;
		else if (t < -32768)
			return 16'sh8000;
		return t[15:0];
	endfunction

endpackage

// File: rtl/etq_cordic.sv
module etq_cordic (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [etq_pkg::ANGLE_BITS-1:0]  angle,
	output etq_pkg::cs_t                           cs
);
	import etq_pkg::*;

	logic signed [CW-1:0] x_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] y_s [CORDIC_STAGES+1];
	logic signed [ZW-1:0] z_s [CORDIC_STAGES+1];

	assign x_s[0] = INV_GAIN;
	assign y_s[0] = '0;
	assign z_s[0] = ZW'(angle) <<< (32 - ANGLE_BITS);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
		if (i % 4 == 3 || i == CORDIC_STAGES-1) begin : g_reg
			always_ff @(posedge clk) begin
				if (en) begin
					if (!z_s[i][ZW-1]) begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] - atan_t(i);
					end else begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] + atan_t(i);
					end
				end
			end
		end else begin : g_comb
			always_comb begin
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] = x_s[i] - (y_s[i] >>> i);
					y_s[i+1] = y_s[i] + (x_s[i] >>> i);
					z_s[i+1] = z_s[i] - atan_t(i);
				end else begin
					x_s[i+1] = x_s[i] + (y_s[i] >>> i);
					y_s[i+1] = y_s[i] - (x_s[i] >>> i);
					z_s[i+1] = z_s[i] + atan_t(i);
				end
			end
		end
	end

	assign cs.c = x_s[CORDIC_STAGES];
	assign cs.s = y_s[CORDIC_STAGES];
endmodule

// File: rtl/etq_qmul.sv
module etq_qmul (
	input  logic           clk,
	input  logic           en,
	input  etq_pkg::cs_t   cx,
	input  etq_pkg::cs_t   cy,
	input  etq_pkg::cs_t   cz,
	output etq_pkg::req_out_t q
);
	import etq_pkg::*;
	localparam int PW = CW + CW + 2;

	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [CW-1:0] ys_s1, yc_s1;
	logic signed [CW-1:0] tx_s2, ty_s2, tz_s2, tw_s2, ys_s2, yc_s2;
	logic signed [PW-1:0] m [8];
	logic signed [PW-1:0] m_s3 [8];
	logic signed [CW-1:0] rx_s3, ry_s3, rz_s3, rw_s3;

	// qz*qx: x=cz.c*sx, y=sz*sx, z=sz*cx, w=cz*cx
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= PW'(cz.c * cx.s);
			p1_s1 <= PW'(cz.s * cx.s);
			p2_s1 <= PW'(cz.s * cx.c);
			p3_s1 <= PW'(cz.c * cx.c);
			ys_s1 <= cy.s;
			yc_s1 <= cy.c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s2 <= rnd30(p0_s1);
			ty_s2 <= rnd30(p1_s1);
			tz_s2 <= rnd30(p2_s1);
			tw_s2 <= rnd30(p3_s1);
			ys_s2 <= ys_s1;
			yc_s2 <= yc_s1;
		end
	end

	assign m[0] = PW'(tx_s2 * yc_s2);
	assign m[1] = PW'(tz_s2 * ys_s2);
	assign m[2] = PW'(tw_s2 * ys_s2);
	assign m[3] = PW'(ty_s2 * yc_s2);
	assign m[4] = PW'(tz_s2 * yc_s2);
	assign m[5] = PW'(tx_s2 * ys_s2);
	assign m[6] = PW'(tw_s2 * yc_s2);
	assign m[7] = PW'(ty_s2 * ys_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 8; k++)
				m_s3[k] <= m[k];
		end
	end

	always_comb begin
		rx_s3 = rnd30(m_s3[0] - m_s3[1]);
		ry_s3 = rnd30(m_s3[2] + m_s3[3]);
		rz_s3 = rnd30(m_s3[4] + m_s3[5]);
		rw_s3 = rnd30(m_s3[6] - m_s3[7]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.quat_x <= to_out(rx_s3);
			q.quat_y <= to_out(ry_s3);
			q.quat_z <= to_out(rz_s3);
			q.quat_w <= to_out(rw_s3);
		end
	end
endmodule

// File: rtl/euler_to_quaternion_zxy_core.sv
// channel | signals                      | payload
// in      | in_valid, in_ready, in_data  | angle_x, angle_y, angle_z
// out     | out_valid, out_ready, out_data | quat_x, quat_y, quat_z, quat_w
// Accepts one request per cycle unless the output stalls; the path holds ceil(CORDIC_STAGES/4)
// CORDIC register stages plus four product stages.
// Whole pipeline advances together when the output is free or taken.
// Reset clears valid bits only; a stall holds every stage.
module euler_to_quaternion_zxy_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  etq_pkg::req_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output etq_pkg::req_out_t out_data
);
	import etq_pkg::*;
	localparam int CREGS = (CORDIC_STAGES - 1) / 4 + 1;
	localparam int LAT   = CREGS + 4;

	logic en;
	logic [LAT-1:0] vld_q;
	cs_t cx, cy, cz;

	assign en       = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	etq_cordic u_cx (.clk, .en, .angle(in_data.angle_x), .cs(cx));
	etq_cordic u_cy (.clk, .en, .angle(in_data.angle_y), .cs(cy));
	etq_cordic u_cz (.clk, .en, .angle(in_data.angle_z), .cs(cz));

	etq_qmul u_qm (.clk, .en, .cx, .cy, .cz, .q(out_data));

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
`endif
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import etq_pkg::*;

	localparam int LATENCY = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int N_RANDOM = 850;

	localparam longint INV_GAIN_Q30 = 652032874;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_in_t in_data;
	logic out_valid;
	logic out_ready;
	req_out_t out_data;

	int unsigned errors;
	int unsigned idle_cycles;
	bit stim_done;

	euler_to_quaternion_zxy_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	function automatic longint floor_div(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_turn(int i);
		longint tab[32] = '{
			64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
			64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
			64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
			64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
			64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
			64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001,
			64'h0, 64'h0};
		return tab[i];
	endfunction

	function automatic void half_angle_sincos(input logic signed [ANGLE_BITS-1:0] ang,
			output longint c, output longint s);
		longint z, x, y, dx, dy, t;
		z = longint'(ang) * (longint'(1) << (32 - ANGLE_BITS));
		x = INV_GAIN_Q30;
		y = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			dx = floor_div(y, i);
			dy = floor_div(x, i);
			t = atan_turn(i) * 2;
			if (z >= 0) begin
				x -= dx; y += dy; z -= t;
			end else begin
				x += dx; y -= dy; z += t;
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint round_q30(longint v);
		return (v + (longint'(1) << (WORK_FRAC - 1))) >>> WORK_FRAC;
	endfunction

	function automatic void hamilton(input longint p[4], input longint q[4],
			output longint r[4]);
		r[0] = round_q30(p[3]*q[0] + p[0]*q[3] + p[1]*q[2] - p[2]*q[1]);
		r[1] = round_q30(p[3]*q[1] + p[1]*q[3] + p[2]*q[0] - p[0]*q[2]);
		r[2] = round_q30(p[3]*q[2] + p[2]*q[3] + p[0]*q[1] - p[1]*q[0]);
		r[3] = round_q30(p[3]*q[3] - p[0]*q[0] - p[1]*q[1] - p[2]*q[2]);
	endfunction

	function automatic logic signed [15:0] to_q15(longint v);
		longint o;
		int sh;
		sh = WORK_FRAC - OUT_FRAC_BITS;
		o = (sh == 0) ? v : ((v + (longint'(1) << (sh - 1))) >>> sh);
		if (o > 32767)
			o = 32767;
		if (o < -32768)
			o = -32768;
		return 16'(o);
	endfunction

	function automatic req_out_t predict_quat(req_in_t a);
		longint qx[4], qy[4], qz[4], t[4], r[4];
		longint c, s;
		req_out_t q;
		half_angle_sincos(a.angle_x, c, s);
		qx = '{s, 0, 0, c};
		half_angle_sincos(a.angle_y, c, s);
		qy = '{0, s, 0, c};
		half_angle_sincos(a.angle_z, c, s);
		qz = '{0, 0, s, c};
		hamilton(qz, qx, t);
		hamilton(t, qy, r);
		q.quat_x = to_q15(r[0]);
		q.quat_y = to_q15(r[1]);
		q.quat_z = to_q15(r[2]);
		q.quat_w = to_q15(r[3]);
		return q;
	endfunction

	class quat_scoreboard;
		req_out_t pending[$];

		function void note_request(req_in_t a);
			pending.push_back(predict_quat(a));
		endfunction

		function void check_result(req_out_t got);
			req_out_t exp_q;
			if (pending.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
				return;
			end
			exp_q = pending.pop_front();
			if (got.quat_x !== exp_q.quat_x) begin
				$error("quat_x expected %0d got %0d", exp_q.quat_x, got.quat_x);
				errors++;
			end
			if (got.quat_y !== exp_q.quat_y) begin
				$error("quat_y expected %0d got %0d", exp_q.quat_y, got.quat_y);
				errors++;
			end
			if (got.quat_z !== exp_q.quat_z) begin
				$error("quat_z expected %0d got %0d", exp_q.quat_z, got.quat_z);
				errors++;
			end
			if (got.quat_w !== exp_q.quat_w) begin
				$error("quat_w expected %0d got %0d", exp_q.quat_w, got.quat_w);
				errors++;
			end
		endfunction
	endclass

	quat_scoreboard quats;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				quats.note_request(in_data);
			if (out_valid && out_ready)
				quats.check_result(out_data);
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		int unsigned phase;
		phase = $urandom_range(0, 99);
		if (!arst_n)
			out_ready <= 1'b0;
		else if (stim_done)
			out_ready <= (phase < 80);
		else
			case ($urandom_range(0, 3))
				0: out_ready <= 1'b1;
				1: out_ready <= (phase < 50);
				2: out_ready <= (phase < 90);
				default: out_ready <= (phase < 15);
			endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_request(req_in_t a);
		in_valid <= 1'b1;
		in_data <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic pause_sender(int n);
		in_valid <= 1'b0;
		repeat (n)
			@(posedge clk);
	endtask

	function automatic logic signed [15:0] random_angle();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			3: return 16'(16'h4000 + int'($urandom_range(0, 16)) - 8);
			4: return 16'(16'hC000 + int'($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [15:0] corners[8];
		req_in_t a;
		int burst;

		corners = '{16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh4000,
			16'shC000, 16'sh0001, 16'shFFFF, 16'sh2000};
		quats = new();
		errors = 0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 8; i++) begin
			a.angle_x = corners[i];
			a.angle_y = corners[(i + 3) % 8];
			a.angle_z = corners[(i + 5) % 8];
			send_request(a);
		end
		for (int i = 0; i < 3; i++) begin
			a = '0;
			if (i == 0) a.angle_x = 16'sh8000;
			if (i == 1) a.angle_y = 16'sh8000;
			if (i == 2) a.angle_z = 16'sh8000;
			send_request(a);
		end
		a = '{16'sh8000, 16'sh8000, 16'sh8000};
		send_request(a);
		a = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
		send_request(a);
		a = '{16'sh5555, 16'shAAAA, 16'sh5555};
		send_request(a);
		a = '{16'shAAAA, 16'sh5555, 16'shAAAA};
		send_request(a);

		pause_sender(0);
		while (quats.pending.size() != 0)
			@(posedge clk);

		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				a.angle_x = random_angle();
				a.angle_y = random_angle();
				a.angle_z = random_angle();
				send_request(a);
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 12));
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;

		while (quats.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY * 4)
			@(posedge clk);
		if (errors == 0 && quats.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: euler_to_quaternion_zxy_core.f
rtl/etq_pkg.sv
rtl/etq_cordic.sv
rtl/etq_qmul.sv
rtl/euler_to_quaternion_zxy_core.sv
verif/tb.sv
